// ===== design/tlmtc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the trie token counter.
package tlmtc_pkg;

	localparam int MAX_NODES_DEF     = 1024;
	localparam int MAX_TOKEN_LEN_DEF = 64;
	localparam int COUNT_W           = 24;
	localparam int STATUS_W          = 2;
	localparam int BYTE_W            = 8;
	localparam int OUT_TDATA_W       = 32;

	localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

	localparam logic FUNC_VOCAB  = 1'b0;
	localparam logic FUNC_TEXT   = 1'b1;
	localparam logic KIND_COUNT  = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	typedef struct packed {
		logic clr_wr;
		logic accept_ins;
		logic accept_text;
		logic ins_skip;
		logic ct_rd_ins;
		logic ins_eval;
		logic ins_end;
		logic la_rd;
		logic ct_rd_scan;
		logic scan_eval;
		logic take;
		logic text_done;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic ins_blocked;
		logic pos_lt_fill;
		logic must_take;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/tlmtc_ram.sv =====
// Generic single-port RAM with registered read data.
module tlmtc_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [W-1:0]             wdata,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== design/tlmtc_ctrl.sv =====
// Controller state machine that sequences clearing, trie inserts and the text walk.
module tlmtc_ctrl
	import tlmtc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_func,
	output logic     in_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_INS_RD   = 4'd2;
	localparam logic [3:0] S_INS_EVAL = 4'd3;
	localparam logic [3:0] S_INS_END  = 4'd4;
	localparam logic [3:0] S_SCAN     = 4'd5;
	localparam logic [3:0] S_LA_WAIT  = 4'd6;
	localparam logic [3:0] S_CT_WAIT  = 4'd7;
	localparam logic [3:0] S_EMIT     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (in_func == FUNC_TEXT) begin
						cmd.accept_text = 1'b1;
						state_d         = S_SCAN;
					end else begin
						cmd.accept_ins = 1'b1;
						state_d        = S_INS_RD;
					end
				end
			end
			S_INS_RD: begin
				if (stat.ins_blocked) begin
					cmd.ins_skip = 1'b1;
					state_d      = S_INS_END;
				end else begin
					cmd.ct_rd_ins = 1'b1;
					state_d       = S_INS_EVAL;
				end
			end
			S_INS_EVAL: begin
				cmd.ins_eval = 1'b1;
				state_d      = S_INS_END;
			end
			S_INS_END: begin
				if (!stat.last) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.ins_end = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_SCAN: begin
				if (stat.pos_lt_fill) begin
					cmd.la_rd = 1'b1;
					state_d   = S_LA_WAIT;
				end else if (stat.must_take) begin
					cmd.take = 1'b1;
				end else if (stat.last) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LA_WAIT: begin
				cmd.ct_rd_scan = 1'b1;
				state_d        = S_CT_WAIT;
			end
			S_CT_WAIT: begin
				cmd.scan_eval = 1'b1;
				state_d       = S_SCAN;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.text_done = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/tlmtc_dp.sv =====
// Datapath with the trie table, the lookahead buffer, the walk registers and the result register.
module tlmtc_dp
	import tlmtc_pkg::*;
#(
	parameter int MAX_NODES     = MAX_NODES_DEF,
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               cmd,
	output dp_stat_t               stat,
	input  logic [BYTE_W-1:0]      in_byte,
	input  logic                   in_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic                   out_kind
);

	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int FREE_W   = NODE_W + 1;
	localparam int CT_AW    = NODE_W + BYTE_W;
	localparam int CT_DEPTH = MAX_NODES * 256;
	localparam int ENT_W    = NODE_W + 1;
	localparam int LEN_W    = $clog2(MAX_TOKEN_LEN + 1);
	localparam int LA_AW    = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
	localparam int LA_DEPTH = 2 ** LA_AW;
	localparam int PAD_W    = OUT_TDATA_W - COUNT_W - STATUS_W;

	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(MAX_NODES);

	logic [CT_AW-1:0]    clr_addr_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                last_q;
	logic [NODE_W-1:0]   ins_cur_q;
	logic [LEN_W-1:0]    ins_len_q;
	logic [STATUS_W-1:0] ins_err_q;
	logic [FREE_W-1:0]   free_q;
	logic [CT_AW-1:0]    parent_q;
	logic [LA_AW-1:0]    head_q;
	logic [LEN_W-1:0]    fill_q;
	logic [LEN_W-1:0]    pos_q;
	logic [NODE_W-1:0]   cur_q;
	logic [LEN_W-1:0]    best_q;
	logic [COUNT_W-1:0]  count_q;
	logic                out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                out_kind_q;

	logic                ct_we;
	logic [CT_AW-1:0]    ct_addr;
	logic [ENT_W-1:0]    ct_wdata;
	logic [ENT_W-1:0]    ct_rdata;
	logic                la_we;
	logic [LA_AW-1:0]    la_addr;
	logic [BYTE_W-1:0]   la_rdata;

	logic [NODE_W-1:0]   child;
	logic                child_term;
	logic                ins_new;
	logic                ins_full;
	logic [CT_AW-1:0]    ins_addr;
	logic [LEN_W-1:0]    take_n;
	logic                out_free;

	assign child      = ct_rdata[NODE_W-1:0];
	assign child_term = ct_rdata[NODE_W];
	assign ins_addr   = {ins_cur_q, byte_q};
	assign ins_new    = (child == '0);
	assign ins_full   = (free_q >= FREE_MAX);
	assign take_n     = (best_q != '0) ? best_q : LEN_W'(1);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		ct_we    = 1'b0;
		ct_addr  = ins_addr;
		ct_wdata = '0;
		if (cmd.clr_wr) begin
			ct_we   = 1'b1;
			ct_addr = clr_addr_q;
		end else if (cmd.ct_rd_scan) begin
			ct_addr = {cur_q, la_rdata};
		end else if (cmd.ins_eval) begin
			ct_we    = ins_new && !ins_full;
			ct_wdata = {1'b0, free_q[NODE_W-1:0]};
		end else if (cmd.ins_end) begin
			ct_we    = (ins_err_q == ST_STORED);
			ct_addr  = parent_q;
			ct_wdata = {1'b1, ins_cur_q};
		end
	end

	assign la_we   = cmd.accept_text;
	assign la_addr = cmd.la_rd ? (head_q + pos_q[LA_AW-1:0])
	                           : (head_q + fill_q[LA_AW-1:0]);

	tlmtc_ram #(
		.W     (ENT_W),
		.DEPTH (CT_DEPTH)
	) u_child_ram (
		.clk   (clk),
		.we    (ct_we),
		.addr  (ct_addr),
		.wdata (ct_wdata),
		.rdata (ct_rdata)
	);

	tlmtc_ram #(
		.W     (BYTE_W),
		.DEPTH (LA_DEPTH)
	) u_look_ram (
		.clk   (clk),
		.we    (la_we),
		.addr  (la_addr),
		.wdata (in_byte),
		.rdata (la_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			last_q      <= 1'b0;
			ins_cur_q   <= '0;
			ins_len_q   <= '0;
			ins_err_q   <= ST_STORED;
			free_q      <= FREE_W'(1);
			head_q      <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			cur_q       <= '0;
			best_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + CT_AW'(1);
			end
			if (cmd.accept_ins || cmd.accept_text) begin
				last_q <= in_last;
			end
			if (cmd.accept_text) begin
				fill_q <= fill_q + LEN_W'(1);
			end
			if (cmd.ins_skip && ins_err_q == ST_STORED) begin
				ins_err_q <= ST_TOO_LONG;
			end
			if (cmd.ins_eval) begin
				if (!ins_new) begin
					ins_cur_q <= child;
					ins_len_q <= ins_len_q + LEN_W'(1);
				end else if (!ins_full) begin
					ins_cur_q <= free_q[NODE_W-1:0];
					ins_len_q <= ins_len_q + LEN_W'(1);
					free_q    <= free_q + FREE_W'(1);
				end else begin
					ins_err_q <= ST_FULL;
				end
			end
			if (cmd.ins_end) begin
				ins_cur_q <= '0;
				ins_len_q <= '0;
				ins_err_q <= ST_STORED;
			end
			if (cmd.scan_eval) begin
				if (child != '0) begin
					cur_q <= child;
					pos_q <= pos_q + LEN_W'(1);
					if (child_term) begin
						best_q <= pos_q + LEN_W'(1);
					end
				end
			end
			if (cmd.take || (cmd.scan_eval && child == '0)) begin
				head_q  <= head_q + take_n[LA_AW-1:0];
				fill_q  <= fill_q - take_n;
				pos_q   <= '0;
				cur_q   <= '0;
				best_q  <= '0;
				count_q <= count_q + COUNT_W'(count_q != '1);
			end
			if (cmd.text_done) begin
				fill_q  <= '0;
				pos_q   <= '0;
				cur_q   <= '0;
				best_q  <= '0;
				count_q <= '0;
			end
			if (cmd.ins_end || cmd.text_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_ins) begin
			byte_q <= in_byte;
		end
		if (cmd.ins_eval) begin
			parent_q <= ins_addr;
		end
		if (cmd.ins_end) begin
			out_kind_q <= KIND_INSERT;
			out_data_q <= {PAD_W'(0), ins_err_q, COUNT_W'(0)};
		end else if (cmd.text_done) begin
			out_kind_q <= KIND_COUNT;
			out_data_q <= {PAD_W'(0), ST_STORED, count_q};
		end
	end

	assign stat.clr_last    = &clr_addr_q;
	assign stat.ins_blocked = (ins_err_q != ST_STORED) || (ins_len_q >= LEN_MAX);
	assign stat.pos_lt_fill = (pos_q < fill_q);
	assign stat.must_take   = (fill_q >= LEN_MAX) || (last_q && fill_q != '0);
	assign stat.last        = last_q;
	assign stat.out_free    = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_kind  = out_kind_q;

endmodule

// ===== design/trie_longest_match_token_counter_top.sv =====
// Top level of the trie longest-match token counter: controller, datapath and checks.
//
//  Channel  Dir  Beat fields
//  s_*      in   tdata[7:0] byte_value, tuser[0] func, tlast last_byte
//  m_*      out  tdata[23:0] text tokens, tdata[25:24] insert_status, tuser[0] result_kind
//
// After reset every entry of the trie table is cleared; no beat is taken then.
// A vocabulary byte follows or adds a trie child; a byte of a failed token is skipped.
// A text byte is buffered; the walk then reads each buffered byte and its trie entry, and
// the tokens left at the buffer's end are taken in turn; a text's last byte sends the result.
// The result register frees the input side; a result waits only on a still-held earlier one.
module trie_longest_match_token_counter_top
	import tlmtc_pkg::*;
#(
	parameter int MAX_NODES     = MAX_NODES_DEF,
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,  // byte_value
	input  logic [0:0]             s_tuser,  // func
	input  logic                   s_tlast,  // last_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // text tokens, insert_status, zero pad
	output logic [0:0]             m_tuser   // result_kind
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	tlmtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (s_tuser[0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tlmtc_dp #(
		.MAX_NODES     (MAX_NODES),
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser[0])
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:24] != 2'd3)
		else $error("insert status out of range");

	a_insert_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == KIND_INSERT) |-> m_tdata[23:0] == '0)
		else $error("insert report carries a count");

	a_count_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == KIND_COUNT) |-> m_tdata[25:24] == ST_STORED)
		else $error("count result carries a status");

	a_table_port: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.ct_rd_ins, cmd.ct_rd_scan, cmd.ins_eval, cmd.ins_end}))
		else $error("trie table port claimed twice");

endmodule
